[src/three_wheel_odometry_update_defines.svh]
// assertion macros for the odometry block checker
`ifndef THREE_WHEEL_ODOMETRY_UPDATE_DEFINES_SVH
`define THREE_WHEEL_ODOMETRY_UPDATE_DEFINES_SVH
// implication checked on every clock, quiet during reset
`define TWO_ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
// next-cycle implication
`define TWO_ASSERT_NXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`endif

[src/two_pkg.sv]
// shared types and constants for the odometry block
package two_pkg;
	localparam int CORDIC_STEPS = 30;
	localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
	localparam logic signed [63:0] CORDIC_K = 64'sd652032874;
	localparam logic signed [63:0] PI_Q40 = 64'sh3243F6A8886;
	localparam logic signed [63:0] TWO_PI_Q40 = 64'sh6487ED5110B;
	localparam logic signed [63:0] HALF_PI_Q40 = 64'sh1921FB54443;
	localparam logic signed [63:0] DEG_PER_RAD_Q24 = 64'sd961263669;
	localparam logic [60:0] MUL_LIMIT = 61'h1000000000000000;
	// 2^63 / 360 rounded, reciprocal for the travel scaling
	localparam logic signed [63:0] RECIP_360_Q63 = 64'sd25620477880152155;

	localparam logic [2:0] REG_CIRC = 3'd0;
	localparam logic [2:0] REG_LOFF = 3'd1;
	localparam logic [2:0] REG_ROFF = 3'd2;
	localparam logic [2:0] REG_BOFF = 3'd3;
	localparam logic [2:0] REG_SX = 3'd4;
	localparam logic [2:0] REG_SY = 3'd5;

	// signed mag-multiply request
	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic [5:0] sh;
	} mul_req_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0: atan_q30 = 32'h3243F6A8;
			5'd1: atan_q30 = 32'h1DAC6705;
			5'd2: atan_q30 = 32'h0FADBAFC;
			5'd3: atan_q30 = 32'h07F56EA6;
			5'd4: atan_q30 = 32'h03FEAB76;
			5'd5: atan_q30 = 32'h01FFD55B;
			5'd6: atan_q30 = 32'h00FFFAAA;
			5'd7: atan_q30 = 32'h007FFF55;
			5'd8: atan_q30 = 32'h003FFFEA;
			5'd9: atan_q30 = 32'h001FFFFD;
			5'd10: atan_q30 = 32'h000FFFFF;
			5'd11: atan_q30 = 32'h0007FFFF;
			5'd12: atan_q30 = 32'h0003FFFF;
			5'd13: atan_q30 = 32'h0001FFFF;
			5'd14: atan_q30 = 32'h0000FFFF;
			5'd15: atan_q30 = 32'h00007FFF;
			5'd16: atan_q30 = 32'h3FFF;
			5'd17: atan_q30 = 32'h1FFF;
			5'd18: atan_q30 = 32'hFFF;
			5'd19: atan_q30 = 32'h7FF;
			5'd20: atan_q30 = 32'h3FF;
			5'd21: atan_q30 = 32'h1FF;
			5'd22: atan_q30 = 32'hFF;
			5'd23: atan_q30 = 32'h7F;
			5'd24: atan_q30 = 32'h3F;
			5'd25: atan_q30 = 32'h1F;
			5'd26: atan_q30 = 32'hF;
			5'd27: atan_q30 = 32'h7;
			5'd28: atan_q30 = 32'h3;
			5'd29: atan_q30 = 32'h1;
			default: atan_q30 = 32'h0;
		endcase
	endfunction
endpackage

[src/three_wheel_odometry_update.sv]
// three tracking-wheel odometry update, top level with sequencer
// usage:
//  - configuration: cfg_we/cfg_index/cfg_data write one register per clock,
//    index 0 circumference, 1..3 offsets, 4..5 start position; only when idle
//  - input stream s_axis: tuser = restart, tdata = left, right, back counts
//  - output stream m_axis: tdata = x_pos, y_pos, heading_rad, heading_deg,
//    tuser = offset_fault
//  - one sample is processed at a time; s_axis_tready is low while busy
//  - after the input transaction, three multiplier passes scale the wheel
//    travel, then come up to two divisions (heading change, chord factor),
//    one or two cordic passes and up to nine more multiplier passes before
//    m_axis_tvalid rises
//  - a turning sample takes the longest path, one with a zero offset sum the
//    shortest; the next sample is taken only after the result is delivered
//  - the result sits in an output register; while the receiver stalls the
//    block holds it and does not take a new sample
//  - reset clears position, heading and previous counts to zero
module three_wheel_odometry_update import two_pkg::*; #(
	parameter int ENCODER_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [39:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// left_count, right_count, back_count from bit 0
	input  logic [3*ENCODER_BITS-1:0] s_axis_tdata,
	// restart
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// x_pos, y_pos, heading_rad, heading_deg from bit 0
	output logic [143:0] m_axis_tdata,
	// offset_fault
	output logic m_axis_tuser
);
	localparam int EB = ENCODER_BITS;

	// sequencer state codes
	localparam logic [4:0] ST_IDLE = 5'd0;
	localparam logic [4:0] ST_TRV = 5'd1;
	localparam logic [4:0] ST_TRVW = 5'd2;
	localparam logic [4:0] ST_ANG = 5'd3;
	localparam logic [4:0] ST_ANGW = 5'd4;
	localparam logic [4:0] ST_SC1 = 5'd5;
	localparam logic [4:0] ST_SC1W = 5'd6;
	localparam logic [4:0] ST_KDIV = 5'd7;
	localparam logic [4:0] ST_KDIVW = 5'd8;
	localparam logic [4:0] ST_CHM = 5'd9;
	localparam logic [4:0] ST_CHMW = 5'd10;
	localparam logic [4:0] ST_SC2 = 5'd11;
	localparam logic [4:0] ST_SC2W = 5'd12;
	localparam logic [4:0] ST_ROT = 5'd13;
	localparam logic [4:0] ST_ROTW = 5'd14;
	localparam logic [4:0] ST_DEG = 5'd15;
	localparam logic [4:0] ST_DEGW = 5'd16;
	localparam logic [4:0] ST_OUT = 5'd17;

	logic [4:0] st_q;
	logic [1:0] k_q;
	logic [23:0] circ_q, loff_q, roff_q, boff_q;
	logic signed [39:0] sx_q, sy_q, px_q, py_q;
	logic signed [31:0] hd_q;
	logic signed [EB-1:0] pl_q, pr_q, pb_q;
	logic signed [EB-1:0] cl_q, cr_q, cb_q;
	logic signed [63:0] d_q [3];
	logic signed [63:0] a_q, sh_q, sp_q, cp_q, h_q [2], kv_q, acc_q, nx_q;
	logic fault_q;
	logic [23:0] off_sel;
	logic [63:0] div_num, div_den, div_quo;
	logic div_start, div_done;
	mul_req_t mreq;
	logic mul_done;
	logic signed [63:0] mul_res;
	logic cor_start, cor_done;
	logic signed [63:0] cor_ang, cor_s, cor_c;
	logic signed [EB-1:0] dlt;
	logic [63:0] dmag;
	logic [24:0] den;
	logic [63:0] amag;
	logic signed [63:0] dsel;
	logic [31:0] hd_sat;
	logic [31:0] deg_q;
	logic [63:0] trv_x, trv_x_q, trv_m, trv_q360, trv_q;
	logic signed [63:0] trv_d;
	logic signed [63:0] dd;
	logic [63:0] angm;

	assign den = {1'b0, loff_q} + {1'b0, roff_q};
	assign amag = a_q[63] ? 64'(-a_q) : a_q;
	assign off_sel = (k_q[1]) ? boff_q : roff_q;
	assign dd = d_q[0] - d_q[1];
	assign angm = dd[63] ? 64'(-dd) : dd;

	// difference of the selected wheel, wrapped to encoder width
	always_comb begin
		case (k_q)
			2'd0: dlt = EB'(cl_q - pl_q);
			2'd1: dlt = EB'(cr_q - pr_q);
			default: dlt = EB'(cb_q - pb_q);
		endcase
		dmag = dlt[EB-1] ? 64'(-$signed(64'(dlt))) : 64'($signed(dlt));
		dsel = k_q[1] ? d_q[2] : d_q[1];
	end

	// travel = (|delta|*circ + 180) / 360 by reciprocal product, the rounded
	// estimate is at most one above the quotient and is stepped back once
	always_comb begin
		trv_x = 64'(dmag[EB-1:0] * circ_q) + 64'd180;
		trv_m = mul_res;
		trv_q360 = (trv_m << 8) + (trv_m << 6) + (trv_m << 5) + (trv_m << 3);
		trv_q = (trv_q360 > trv_x_q) ? trv_m - 64'd1 : trv_m;
		trv_d = dlt[EB-1] ? -$signed(trv_q) : $signed(trv_q);
	end

	// shared divider operands per sequencer step
	always_comb begin
		div_start = 1'b0;
		div_num = 64'd0;
		div_den = 64'd1;
		case (st_q)
			ST_ANG: begin
				div_start = 1'b1;
				// a quotient of 128.0 or more saturates; keep the shifted numerator in range
				if (angm >= {32'd0, den, 7'd0}) begin
					div_num = '1;
					div_den = 64'd1;
				end else begin
					div_num = angm << 24;
					div_den = {39'd0, den};
				end
			end
			ST_KDIV: begin
				div_start = 1'b1;
				div_num = (sh_q[63] ? 64'(-sh_q) : sh_q) << 25;
				div_den = amag;
			end
			default: ;
		endcase
	end

	// multiplier operands
	always_comb begin
		mreq = '0;
		case (st_q)
			ST_TRV: begin
				mreq.start = 1'b1;
				mreq.a = $signed(trv_x);
				mreq.b = RECIP_360_Q63;
				mreq.sh = 6'd63;
			end
			ST_CHM: begin
				mreq.start = 1'b1;
				mreq.a = k_q[0] ? $signed({40'd0, off_sel}) : dsel;
				mreq.b = k_q[0] ? sh_q : kv_q;
				mreq.sh = k_q[0] ? 6'd29 : 6'd30;
			end
			ST_ROT: begin
				mreq.start = 1'b1;
				mreq.sh = 6'd30;
				case (k_q)
					2'd0: begin mreq.a = h_q[0]; mreq.b = sp_q; end
					2'd1: begin mreq.a = h_q[1]; mreq.b = cp_q; end
					2'd2: begin mreq.a = h_q[0]; mreq.b = cp_q; end
					default: begin mreq.a = h_q[1]; mreq.b = sp_q; end
				endcase
			end
			ST_DEG: begin
				mreq.start = 1'b1;
				mreq.a = 64'(hd_q);
				mreq.b = DEG_PER_RAD_Q24;
				mreq.sh = 6'd32;
			end
			default: ;
		endcase
	end

	assign cor_start = (st_q == ST_SC1) || (st_q == ST_SC2);
	assign cor_ang = (st_q == ST_SC1) ? a_q : a_q + 64'(hd_q) * 64'sd2;

	two_div u_div (.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo));
	two_mul u_mul (.clk, .arst_n, .req(mreq), .done(mul_done), .res(mul_res));
	two_cordic u_cor (.clk, .arst_n, .start(cor_start), .ang(cor_ang),
		.done(cor_done), .s(cor_s), .c(cor_c));

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = (st_q == ST_OUT);
	assign m_axis_tdata = {deg_q, hd_q, py_q, px_q};
	assign m_axis_tuser = fault_q;

	logic signed [64:0] sum;
	logic signed [63:0] hsum;
	assign sum = $signed({acc_q[63], acc_q}) + $signed({mul_res[63], mul_res});
	assign hsum = 64'(hd_q) + a_q;
	assign hd_sat = hsum > 64'sd2147483647 ? 32'h7FFFFFFF
		: (hsum < -64'sd2147483648 ? 32'h80000000 : hsum[31:0]);

	function automatic logic [39:0] sat40(input logic signed [63:0] v);
		if (v > 64'sd549755813887) sat40 = 40'h7FFFFFFFFF;
		else if (v < -64'sd549755813888) sat40 = 40'h8000000000;
		else sat40 = v[39:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= 2'd0;
			circ_q <= '0; loff_q <= '0; roff_q <= '0; boff_q <= '0;
			sx_q <= '0; sy_q <= '0; px_q <= '0; py_q <= '0; hd_q <= '0;
			pl_q <= '0; pr_q <= '0; pb_q <= '0;
			fault_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CIRC: circ_q <= cfg_data[23:0];
					REG_LOFF: loff_q <= cfg_data[23:0];
					REG_ROFF: roff_q <= cfg_data[23:0];
					REG_BOFF: boff_q <= cfg_data[23:0];
					REG_SX: sx_q <= cfg_data;
					REG_SY: sy_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: if (s_axis_tvalid) begin
					cl_q <= s_axis_tdata[EB-1:0];
					cr_q <= s_axis_tdata[2*EB-1:EB];
					cb_q <= s_axis_tdata[3*EB-1:2*EB];
					if (s_axis_tuser) begin
						px_q <= sx_q; py_q <= sy_q; hd_q <= '0;
						pl_q <= '0; pr_q <= '0; pb_q <= '0;
					end
					fault_q <= (den == 25'd0);
					k_q <= 2'd0;
					st_q <= ST_TRV;
				end
				ST_TRV: begin
					trv_x_q <= trv_x;
					st_q <= ST_TRVW;
				end
				ST_TRVW: if (mul_done) begin
					d_q[k_q] <= trv_d;
					if (k_q == 2'd2) begin
						pl_q <= cl_q; pr_q <= cr_q; pb_q <= cb_q;
						a_q <= '0;
						// straight-line travel unless a chord correction follows
						h_q[0] <= d_q[1];
						h_q[1] <= trv_d;
						st_q <= (den == 25'd0) ? ST_SC2 : ST_ANG;
					end else begin
						k_q <= k_q + 2'd1;
						st_q <= ST_TRV;
					end
				end
				ST_ANG: st_q <= ST_ANGW;
				ST_ANGW: if (div_done) begin
					// quotient of 2^24-scaled numerator; saturate at 128.0
					logic [63:0] q;
					q = (div_quo >= 64'h80000000) ? 64'h7FFFFFFF : div_quo;
					a_q <= ((d_q[0] - d_q[1]) < 0) ? 64'(-q) : q;
					h_q[0] <= d_q[1];
					h_q[1] <= d_q[2];
					if (q == 64'd0) st_q <= ST_SC2;
					else st_q <= ST_SC1;
				end
				ST_SC1: st_q <= ST_SC1W;
				ST_SC1W: if (cor_done) begin
					sh_q <= cor_s;
					if (amag < 64'd32768) begin
						kv_q <= Q30_ONE;
						k_q <= 2'd0;
						st_q <= ST_CHM;
					end else st_q <= ST_KDIV;
				end
				ST_KDIV: st_q <= ST_KDIVW;
				ST_KDIVW: if (div_done) begin
					kv_q <= (sh_q[63] != a_q[63]) ? 64'(-div_quo) : div_quo;
					k_q <= 2'd0;
					st_q <= ST_CHM;
				end
				// k_q: bit1 selects back wheel, bit0 selects offset term
				ST_CHM: st_q <= ST_CHMW;
				ST_CHMW: if (mul_done) begin
					if (!k_q[0]) acc_q <= mul_res;
					else h_q[k_q[1]] <= sum[63:0];
					if (k_q == 2'd3) st_q <= ST_SC2;
					else begin
						k_q <= k_q + 2'd1;
						st_q <= ST_CHM;
					end
				end
				ST_SC2: st_q <= ST_SC2W;
				ST_SC2W: if (cor_done) begin
					sp_q <= cor_s; cp_q <= cor_c;
					k_q <= 2'd0;
					st_q <= ST_ROT;
				end
				ST_ROT: st_q <= ST_ROTW;
				ST_ROTW: if (mul_done) begin
					case (k_q)
						2'd0: acc_q <= 64'(px_q) + mul_res;
						2'd1: nx_q <= sum[63:0];
						2'd2: acc_q <= 64'(py_q) + mul_res;
						default: begin
							px_q <= sat40(nx_q);
							py_q <= sat40(64'(acc_q - mul_res));
							hd_q <= hd_sat;
						end
					endcase
					if (k_q == 2'd3) st_q <= ST_DEG;
					else begin
						k_q <= k_q + 2'd1;
						st_q <= ST_ROT;
					end
				end
				ST_DEG: st_q <= ST_DEGW;
				ST_DEGW: if (mul_done) begin
					deg_q <= mul_res > 64'sd2147483647 ? 32'h7FFFFFFF
						: (mul_res < -64'sd2147483648 ? 32'h80000000 : mul_res[31:0]);
					st_q <= ST_OUT;
				end
				ST_OUT: if (m_axis_tready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[src/two_mul.sv]
// multi-cycle rounding multiplier, 32x32 partial products, saturates to 2^60
module two_mul import two_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  mul_req_t req,
	output logic done,
	output logic signed [63:0] res
);
	logic [63:0] ua_q, ub_q;
	logic neg_q;
	logic [5:0] sh_q;
	logic [2:0] ph_q;
	logic [127:0] acc_q;
	logic [63:0] pp;
	logic [127:0] rnd;
	logic [127:0] shr;
	logic [60:0] m;

	always_comb begin
		case (ph_q)
			3'd1: pp = {32'd0, ua_q[31:0]} * {32'd0, ub_q[31:0]};
			3'd2: pp = {32'd0, ua_q[31:0]} * {32'd0, ub_q[63:32]};
			3'd3: pp = {32'd0, ua_q[63:32]} * {32'd0, ub_q[31:0]};
			3'd4: pp = {32'd0, ua_q[63:32]} * {32'd0, ub_q[63:32]};
			default: pp = 64'd0;
		endcase
		rnd = acc_q + (128'd1 << (sh_q - 6'd1));
		shr = rnd >> sh_q;
		m = (shr > {67'd0, MUL_LIMIT}) ? MUL_LIMIT : shr[60:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 3'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				ua_q <= req.a[63] ? 64'(-req.a) : req.a;
				ub_q <= req.b[63] ? 64'(-req.b) : req.b;
				neg_q <= req.a[63] ^ req.b[63];
				sh_q <= req.sh;
				acc_q <= 128'd0;
				ph_q <= 3'd1;
			end else if (ph_q != 3'd0) begin
				case (ph_q)
					3'd1: acc_q <= acc_q + {64'd0, pp};
					3'd2, 3'd3: acc_q <= acc_q + {32'd0, pp, 32'd0};
					3'd4: acc_q <= acc_q + {pp, 64'd0};
					default: acc_q <= acc_q;
				endcase
				if (ph_q == 3'd5) begin
					res <= neg_q ? -$signed({3'd0, m}) : $signed({3'd0, m});
					done <= 1'b1;
					ph_q <= 3'd0;
				end else begin
					ph_q <= ph_q + 3'd1;
				end
			end
		end
	end
endmodule

[src/two_div.sv]
// restoring divider, one quotient bit per cycle
module two_div (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic done,
	output logic [63:0] quo
);
	logic [63:0] rem_q, d_q, n_q;
	logic [6:0] cnt_q;
	logic [64:0] t;

	assign t = {rem_q, n_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				rem_q <= 64'd0;
				n_q <= num;
				d_q <= den;
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				if (t >= {1'b0, d_q}) begin
					rem_q <= 64'(t - {1'b0, d_q});
					n_q <= {n_q[62:0], 1'b1};
				end else begin
					rem_q <= t[63:0];
					n_q <= {n_q[62:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) done <= 1'b1;
			end
		end
	end
	assign quo = n_q;
endmodule

[src/two_cordic.sv]
// iterative cordic sine/cosine in q2.30 of an angle in radians q.25
module two_cordic import two_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [63:0] ang,
	output logic done,
	output logic signed [63:0] s,
	output logic signed [63:0] c
);
	logic signed [63:0] x_q, y_q, z_q;
	logic neg_q;
	logic [5:0] i_q;
	logic [1:0] ph_q;
	logic [2:0] red_q;
	logic signed [63:0] r_q;
	logic signed [63:0] r_in, r_sub;
	logic signed [63:0] ysh, xsh, at;

	// range reduce: angle below 2pi*2^6 in magnitude, lifted to positive,
	// then compare and subtract 2pi*2^k for k from 6 down to 0
	always_comb begin
		r_in = ang * 64'sd32768 + PI_Q40;
		r_sub = (r_q >= (TWO_PI_Q40 <<< red_q)) ? r_q - (TWO_PI_Q40 <<< red_q) : r_q;
		ysh = y_q >>> i_q;
		xsh = x_q >>> i_q;
		at = $signed({32'd0, atan_q30(i_q[4:0])});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				r_q <= (r_in < 0) ? r_in + (TWO_PI_Q40 <<< 6) : r_in;
				red_q <= 3'd6;
				ph_q <= 2'd1;
			end else if (ph_q == 2'd1) begin
				// last step leaves r in [0,2pi), shift it to [-pi,pi)
				if (red_q == 3'd0) begin
					r_q <= r_sub - PI_Q40;
					ph_q <= 2'd2;
				end else begin
					r_q <= r_sub;
					red_q <= red_q - 3'd1;
				end
			end else if (ph_q == 2'd2) begin
				if (r_q > HALF_PI_Q40) begin
					z_q <= (r_q - PI_Q40 + 64'sd512) >>> 10;
					neg_q <= 1'b1;
				end else if (r_q < -HALF_PI_Q40) begin
					z_q <= (r_q + PI_Q40 + 64'sd512) >>> 10;
					neg_q <= 1'b1;
				end else begin
					z_q <= (r_q + 64'sd512) >>> 10;
					neg_q <= 1'b0;
				end
				x_q <= CORDIC_K;
				y_q <= 64'sd0;
				i_q <= 6'd0;
				ph_q <= 2'd3;
			end else if (ph_q == 2'd3) begin
				if (z_q >= 0) begin
					x_q <= x_q - ysh;
					y_q <= y_q + xsh;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + ysh;
					y_q <= y_q - xsh;
					z_q <= z_q + at;
				end
				if (i_q == 6'(CORDIC_STEPS - 1)) begin
					ph_q <= 2'd0;
					done <= 1'b1;
				end
				i_q <= i_q + 6'd1;
			end
		end
	end
	assign s = neg_q ? -y_q : y_q;
	assign c = neg_q ? -x_q : x_q;
endmodule

[src/two_checker.sv]
// port-level checker for the odometry block, bound to the top level
`include "three_wheel_odometry_update_defines.svh"
module two_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [143:0] m_axis_tdata
);
	// never ready for input while holding a result
	`TWO_ASSERT_IMP(a_excl, clk, arst_n, m_axis_tvalid, !s_axis_tready)
	// an accepted sample makes the block busy next cycle
	`TWO_ASSERT_NXT(a_busy, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// a stalled result is held
	`TWO_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	// a delivered result leaves the block ready
	`TWO_ASSERT_NXT(a_free, clk, arst_n, m_axis_tvalid && m_axis_tready, s_axis_tready)
endmodule

bind three_wheel_odometry_update two_checker u_chk (.clk, .arst_n, .s_axis_tvalid,
	.s_axis_tready, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

[sim/tb.sv]
// self-checking testbench for the three tracking-wheel odometry update block
module tb;
	import two_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	// indexes with no register behind them, a write there must change nothing
	localparam logic [2:0] REG_SPARE_A = 3'd6;
	localparam logic [2:0] REG_SPARE_B = 3'd7;

	// arctangent steps in Q2.30, one per cordic iteration
	localparam longint ARC_TAB [30] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF, 64'h3FFF, 64'h1FFF, 64'hFFF, 64'h7FF, 64'h3FF, 64'h1FF,
		64'hFF, 64'h7F, 64'h3F, 64'h1F, 64'hF, 64'h7, 64'h3, 64'h1};

	typedef struct {
		logic restart;
		logic [31:0] left;
		logic [31:0] right;
		logic [31:0] back;
	} sample_t;

	typedef struct {
		logic [39:0] x;
		logic [39:0] y;
		logic [31:0] rad;
		logic [31:0] deg;
		logic fault;
	} pose_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = REG_CIRC;
	logic [39:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [143:0] m_axis_tdata;
	logic m_axis_tuser;

	three_wheel_odometry_update dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always #6 clk = ~clk;

	// pending samples for the driver, expected poses for the checker
	sample_t sample_q[$];
	pose_t pose_q[$];
	int errors = 0;
	int cycles = 0;

	// predictor copy of the registers and of the tracked state
	logic [63:0] circ_r, loff_r, roff_r, boff_r;
	longint startx_r, starty_r;
	logic [31:0] last_l, last_r, last_b;
	longint px, py, hdg;

	// generator memory of the counts it sent last
	logic [31:0] gen_l, gen_r, gen_b;

	function automatic logic [63:0] magn(longint v);
		return v < 0 ? 64'(-v) : 64'(v);
	endfunction

	// rounded, saturated product scaled down by 2^sh
	function automatic longint mul_round(longint p, longint q, int sh);
		logic [127:0] full;
		logic [127:0] res;
		logic neg;
		neg = (p < 0) != (q < 0);
		full = {64'b0, magn(p)} * {64'b0, magn(q)};
		full = full + (128'd1 << (sh - 1));
		res = full >> sh;
		if (res > (128'd1 << 60))
			res = 128'd1 << 60;
		return neg ? -longint'(res[63:0]) : longint'(res[63:0]);
	endfunction

	// encoder delta to inches, rounded half away from zero
	function automatic longint wheel_travel(logic [31:0] cur, logic [31:0] prv);
		logic signed [31:0] dlt;
		logic [63:0] m;
		dlt = cur - prv;
		m = (magn(longint'(dlt)) * circ_r + 64'd180) / 64'd360;
		return dlt < 0 ? -longint'(m) : longint'(m);
	endfunction

	// heading change in Q8.24, truncated and saturated
	function automatic longint turn_angle(longint num, logic [63:0] den);
		logic [63:0] m;
		logic [127:0] q;
		m = magn(num);
		q = {64'b0, m / den};
		if (q >= 128)
			q = 128'h7FFFFFFF;
		else
			q = ({64'b0, m} << 24) / {64'b0, den};
		return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
	endfunction

	// sine and cosine in Q2.30 of an angle in Q.25 radians
	task automatic sin_cos(input longint x25, output longint s, output longint c);
		longint r, x, y, z, nx;
		logic neg;
		r = (x25 * 32768 + PI_Q40) % TWO_PI_Q40;
		x = CORDIC_K;
		y = 0;
		neg = 1'b0;
		if (r < 0)
			r += TWO_PI_Q40;
		r -= PI_Q40;
		// fold into the right half plane
		if (r > HALF_PI_Q40) begin
			r -= PI_Q40;
			neg = 1'b1;
		end else if (r < -HALF_PI_Q40) begin
			r += PI_Q40;
			neg = 1'b1;
		end
		z = (r + 512) >>> 10;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARC_TAB[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARC_TAB[i];
			end
			x = nx;
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endtask

	// arc to chord for one wheel at a nonzero heading change
	function automatic longint chord_len(longint d, logic [63:0] off, longint a, longint s);
		longint k;
		logic [63:0] km;
		if (magn(a) < 64'd32768)
			k = Q30_ONE;
		else begin
			km = (magn(s) << 25) / magn(a);
			k = ((s < 0) != (a < 0)) ? -longint'(km) : longint'(km);
		end
		return mul_round(d, k, 30) + mul_round(longint'(off), s, 29);
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	// advance the predicted pose by one sample
	task automatic odometry_step(input sample_t smp, output pose_t pose);
		longint dl, dr, ds, a, h, h2, sh, ch, sp, cp, nx, ny, dg;
		logic [63:0] den;
		logic fault;
		den = loff_r + roff_r;
		fault = (den == 0);
		a = 0;
		if (smp.restart) begin
			px = startx_r;
			py = starty_r;
			hdg = 0;
			last_l = '0;
			last_r = '0;
			last_b = '0;
		end
		dl = wheel_travel(smp.left, last_l);
		dr = wheel_travel(smp.right, last_r);
		ds = wheel_travel(smp.back, last_b);
		last_l = smp.left;
		last_r = smp.right;
		last_b = smp.back;
		if (!fault)
			a = turn_angle(dl - dr, den);
		if (a != 0) begin
			sin_cos(a, sh, ch);
			h = chord_len(dr, roff_r, a, sh);
			h2 = chord_len(ds, boff_r, a, sh);
		end else begin
			// straight line, no chord correction
			h = dr;
			h2 = ds;
		end
		// rotate by the mid-step heading
		sin_cos(a + 2 * hdg, sp, cp);
		nx = px + mul_round(h, sp, 30) + mul_round(h2, cp, 30);
		ny = py + mul_round(h, cp, 30) - mul_round(h2, sp, 30);
		px = clip(nx, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
		py = clip(ny, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
		hdg = clip(hdg + a, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
		dg = clip(mul_round(hdg, DEG_PER_RAD_Q24, 32), -(64'sd1 <<< 31),
			(64'sd1 <<< 31) - 1);
		pose.x = px[39:0];
		pose.y = py[39:0];
		pose.rad = hdg[31:0];
		pose.deg = dg[31:0];
		pose.fault = fault;
	endtask

	// ---------------------------------------------------------------
	// sample driver: bursts of random length, random gaps in between
	// ---------------------------------------------------------------
	sample_t held, nxt;
	pose_t want;
	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			// a transaction on the input side: predict its pose now
			if (s_axis_tvalid && s_axis_tready) begin
				odometry_step(held, want);
				pose_q.push_back(want);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_axis_tvalid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					nxt = sample_q.pop_front();
					held <= nxt;
					s_axis_tdata <= {nxt.back, nxt.right, nxt.left};
					s_axis_tuser <= nxt.restart;
					s_axis_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 12);
						// a quarter of the bursts follow back to back
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
					end else
						burst_left <= burst_left - 1;
				end else
					s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// result monitor with its own stall pattern
	// ---------------------------------------------------------------
	int stall_mode = 0;
	int mode_left = 0;
	pose_t got, exp_pose;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			mode_left <= 0;
		end else begin
			// the stall pattern is redrawn whenever its countdown runs out
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_left <= $urandom_range(100, 3000);
			end else
				mode_left <= mode_left - 1;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				default: m_axis_tready <= ($urandom_range(0, 15) == 0);
			endcase
			if (m_axis_tvalid && m_axis_tready) begin
				got.x = m_axis_tdata[39:0];
				got.y = m_axis_tdata[79:40];
				got.rad = m_axis_tdata[111:80];
				got.deg = m_axis_tdata[143:112];
				got.fault = m_axis_tuser;
				if (pose_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, actual x=%h y=%h",
						$realtime, got.x, got.y);
				end else begin
					exp_pose = pose_q.pop_front();
					if (got.x !== exp_pose.x) begin
						errors++;
						$display("%0t: x_pos expected %h actual %h", $realtime, exp_pose.x, got.x);
					end
					if (got.y !== exp_pose.y) begin
						errors++;
						$display("%0t: y_pos expected %h actual %h", $realtime, exp_pose.y, got.y);
					end
					if (got.rad !== exp_pose.rad) begin
						errors++;
						$display("%0t: heading_rad expected %h actual %h", $realtime,
							exp_pose.rad, got.rad);
					end
					if (got.deg !== exp_pose.deg) begin
						errors++;
						$display("%0t: heading_deg expected %h actual %h", $realtime,
							exp_pose.deg, got.deg);
					end
					if (got.fault !== exp_pose.fault) begin
						errors++;
						$display("%0t: offset_fault expected %b actual %b", $realtime,
							exp_pose.fault, got.fault);
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// register writes and sample generation
	// ---------------------------------------------------------------

	// back-to-back writes, the predictor copy follows each one
	task automatic write_regs(input logic [2:0] idx [], input logic [39:0] val []);
		for (int i = 0; i < idx.size(); i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			case (idx[i])
				REG_CIRC: circ_r = {40'b0, val[i][23:0]};
				REG_LOFF: loff_r = {40'b0, val[i][23:0]};
				REG_ROFF: roff_r = {40'b0, val[i][23:0]};
				REG_BOFF: boff_r = {40'b0, val[i][23:0]};
				REG_SX: startx_r = longint'(signed'(val[i]));
				REG_SY: starty_r = longint'(signed'(val[i]));
				default: ;
			endcase
		end
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_all(input logic [39:0] c, input logic [39:0] l, input logic [39:0] r,
		input logic [39:0] b, input logic [39:0] sx, input logic [39:0] sy);
		write_regs('{REG_CIRC, REG_LOFF, REG_ROFF, REG_BOFF, REG_SX, REG_SY},
			'{c, l, r, b, sx, sy});
	endtask

	task automatic push_sample(input logic rs, input logic [31:0] l, input logic [31:0] r,
		input logic [31:0] b);
		sample_t smp;
		smp.restart = rs;
		smp.left = l;
		smp.right = r;
		smp.back = b;
		sample_q.push_back(smp);
		if (rs) begin
			gen_l = '0;
			gen_r = '0;
			gen_b = '0;
		end
		gen_l = l;
		gen_r = r;
		gen_b = b;
	endtask

	// mostly smooth driving, some jumps, restarts and pure noise
	task automatic push_random(input int n);
		int pick, fwd, turn;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 70) begin
				fwd = $urandom_range(0, 4000) - 2000;
				turn = $urandom_range(0, 400) - 200;
				push_sample(1'b0, gen_l + fwd + turn, gen_r + fwd - turn,
					gen_b + $urandom_range(0, 600) - 300);
			end else if (pick < 78)
				push_sample(1'b0, gen_l + $urandom, gen_r + $urandom, gen_b + $urandom);
			else if (pick < 88)
				push_sample(1'b1, $urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
					$urandom_range(0, 2000) - 1000);
			else
				push_sample($urandom_range(0, 1), $urandom, $urandom, $urandom);
		end
	endtask

	// let every sample through and every pose come back
	task automatic drain;
		while (sample_q.size() != 0 || s_axis_tvalid || pose_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		circ_r = '0;
		loff_r = '0;
		roff_r = '0;
		boff_r = '0;
		startx_r = 0;
		starty_r = 0;
		last_l = '0;
		last_r = '0;
		last_b = '0;
		px = 0;
		py = 0;
		hdg = 0;
		gen_l = '0;
		gen_r = '0;
		gen_b = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// reset values: zero offsets raise the fault, zero circumference gives no travel
		push_sample(1'b0, 32'd100, 32'd50, 32'd25);
		push_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF);
		drain();

		// nominal robot, directed corners
		set_all(40'd566231, 40'd393216, 40'd393216, 40'd327680, 40'd0, 40'd0);
		push_sample(1'b1, 32'd0, 32'd0, 32'd0);
		push_sample(1'b0, 32'd360, 32'd360, 32'd0);         // straight, no turn
		push_sample(1'b0, 32'd361, 32'd359, 32'd1);         // tiny turn
		push_sample(1'b0, 32'd1361, 32'd359, 32'd500);      // sizable left turn
		push_sample(1'b0, 32'd1361, 32'd1800, 32'd500);     // right turn
		push_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		push_sample(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h80000000); // wrapping deltas
		push_sample(1'b0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
		push_sample(1'b1, 32'h80000000, 32'h80000000, 32'h80000000); // restart, big counts
		push_sample(1'b1, 32'd5, 32'hFFFFFFFB, 32'hAAAAAAAA);
		push_sample(1'b0, 32'h55555555, 32'hAAAAAAAA, 32'h55555555);
		push_random(110);
		drain();

		// extremes of every register, spare indexes must be ignored
		set_all(40'hFFFFFF, 40'hFFFFFF, 40'hFFFFFF, 40'hFFFFFF, 40'h7FFFFFFFFF, 40'h8000000000);
		write_regs('{REG_SPARE_A, REG_SPARE_B}, '{40'hFFFFFFFFFF, 40'h1234567890});
		push_sample(1'b1, 32'd0, 32'd0, 32'd0);
		push_sample(1'b0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		push_sample(1'b0, 32'h80000000, 32'h7FFFFFFF, 32'h00000000);
		push_random(70);
		drain();

		// left plus right offset zero, back offset still in use
		set_all(40'd600000, 40'd0, 40'd0, 40'd200000, 40'h8000000000, 40'h7FFFFFFFFF);
		push_sample(1'b1, 32'd720, 32'd0, 32'd360);
		push_random(50);
		drain();

		// only one side offset, smallest nonzero denominator
		set_all(40'd1, 40'd1, 40'd0, 40'd0, 40'hFFFFFFFFFF, 40'd1);
		push_sample(1'b1, 32'd360, 32'd0, 32'd0);
		push_random(30);
		drain();

		// random settings
		for (int k = 0; k < 3; k++) begin
			set_all($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
				$urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
				{$urandom, $urandom}, {$urandom, $urandom});
			push_random(55);
			drain();
		end

		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule
